>>> design/ipr_pkg.sv
// Shared types and defaults for the interval paint run counter.
`default_nettype none
package ipr_pkg;

    localparam int unsigned LEVELS_DEF = 10;

    typedef struct packed {
        logic        paint_black;
        logic [9:0]  range_start;
        logic [10:0] range_length;
    } t_paint_req;

    typedef struct packed {
        logic [9:0]  black_runs;
        logic [10:0] black_cells;
    } t_paint_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_VISIT,
        S_VCHK,
        S_PUSH_R,
        S_UP,
        S_JRL,
        S_JRR,
        S_JW,
        S_RPT,
        S_RPT_W
    } t_state;

endpackage
`default_nettype wire

>>> design/interval_paint_run_counter.sv
// Top level: line of black/white cells kept as a lazy segment tree in one memory.
`default_nettype none
// The line holds 2^LEVELS cells, white after reset. Each request paints a
// clipped range black or white and returns the count of maximal black runs
// and of black cells (modulo the field widths). The tree lives in one
// single-port-write, registered-read memory of 2^(LEVELS+1) words; a
// recursive walk visits nodes one at a time. After reset a clearing pass
// writes one word a cycle, all 2^(LEVELS+1) words, before the first request
// is taken. A request that paints nothing goes straight to reading the root
// for its response. Otherwise a fully covered node is written solid; a split
// node is read and, if it holds a pending tag, pushes it to both children;
// on the way up each split node is rebuilt by reading both children and
// writing their join. The root is then read for the response.
// A new request is taken while the previous response still waits.
module interval_paint_run_counter #(
    parameter int unsigned LEVELS = ipr_pkg::LEVELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_ready,
    input  wire ipr_pkg::t_paint_req i_req,
    output logic                    o_rsp_valid,
    input  wire logic               i_rsp_ready,
    output ipr_pkg::t_paint_rsp     o_rsp
);
    import ipr_pkg::*;

    localparam int unsigned CW = LEVELS + 1;
    localparam int unsigned DW = (LEVELS + 1 <= 2) ? 1 : $clog2(LEVELS + 1);
    localparam int unsigned NODES = 2 ** (LEVELS + 1);
    localparam logic [31:0] CELLS32 = 32'(1) << LEVELS;

    typedef struct packed {
        logic          tagc;
        logic          tag;
        logic          rb;
        logic          lb;
        logic [CW-1:0] len;
        logic [CW-1:0] runs;
    } t_node;

    function automatic logic [CW-1:0] lo_of(input logic [CW-1:0] v,
                                            input logic [DW-1:0] d);
        logic [CW-1:0] m;
        m = v & ~(CW'(1) << d);
        return m << (DW'(LEVELS) - d);
    endfunction

    function automatic logic [CW-1:0] size_of(input logic [DW-1:0] d);
        return CW'(1) << (DW'(LEVELS) - d);
    endfunction

    function automatic t_node solid(input logic c, input logic [CW-1:0] size);
        t_node w;
        w = '0;
        w.tag = 1'b1;
        if (c) begin
            w.runs = CW'(1);
            w.len  = size;
            w.lb   = 1'b1;
            w.rb   = 1'b1;
            w.tagc = 1'b1;
        end
        return w;
    endfunction

    function automatic t_node join_nodes(input t_node a, input t_node b);
        t_node w;
        w = '0;
        w.runs = a.runs + b.runs - CW'(a.rb & b.lb);
        w.len  = a.len + b.len;
        w.lb   = a.lb;
        w.rb   = b.rb;
        return w;
    endfunction

    t_node r_mem [NODES];
    t_node r_rdata;
    logic          mem_we, mem_re;
    logic [CW-1:0] mem_waddr, mem_raddr;
    t_node         mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    t_state        r_state, n_state;
    logic [CW-1:0] r_v, n_v, r_a, n_a, r_b, n_b, r_clr, n_clr;
    logic [DW-1:0] r_d, n_d;
    logic          r_col, n_col;
    t_node         r_left, n_left;
    logic          r_out_valid, n_out_valid;
    t_paint_rsp    r_out, n_out;

    logic [CW-1:0] v_lo, v_size, v_hi, v_mid, up_mid;
    logic [CW-1:0] left_c, right_c;
    logic [31:0]   st32, end32, runs32, len32;

    always_comb begin
        v_lo    = lo_of(r_v, r_d);
        v_size  = size_of(r_d);
        v_hi    = v_lo + v_size;
        v_mid   = v_lo + (v_size >> 1);
        up_mid  = lo_of(r_v | CW'(1), r_d);
        left_c  = {r_v[CW-2:0], 1'b0};
        right_c = {r_v[CW-2:0], 1'b1};
        st32    = 32'(i_req.range_start);
        end32   = st32 + 32'(i_req.range_length);
        if (end32 > CELLS32) begin
            end32 = CELLS32;
        end
        runs32  = 32'(r_rdata.runs);
        len32   = 32'(r_rdata.len);
    end

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_d         = r_d;
        n_a         = r_a;
        n_b         = r_b;
        n_col       = r_col;
        n_clr       = r_clr;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (o_rsp_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + CW'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_col = i_req.paint_black;
                    n_a   = st32[CW-1:0];
                    n_b   = end32[CW-1:0];
                    n_v   = CW'(1);
                    n_d   = '0;
                    if (i_req.range_length == '0 || st32 >= CELLS32) begin
                        n_state = S_RPT;
                    end else begin
                        n_state = S_VISIT;
                    end
                end
            end
            S_VISIT: begin
                if (r_a <= v_lo && v_hi <= r_b) begin
                    n_state = S_UP;
                end else begin
                    n_state = S_VCHK;
                end
            end
            S_VCHK, S_PUSH_R: begin
                if (r_state == S_VCHK && r_rdata.tag) begin
                    n_state = S_PUSH_R;
                end else begin
                    n_state = S_VISIT;
                    n_d     = r_d + DW'(1);
                    n_v     = (r_a < v_mid) ? left_c : right_c;
                end
            end
            S_UP: begin
                if (r_d == '0) begin
                    n_state = S_RPT;
                end else if (!r_v[0] && r_b > up_mid) begin
                    n_v     = r_v | CW'(1);
                    n_state = S_VISIT;
                end else begin
                    n_v     = r_v >> 1;
                    n_d     = r_d - DW'(1);
                    n_state = S_JRL;
                end
            end
            S_JRL: n_state = S_JRR;
            S_JRR: begin
                n_left  = r_rdata;
                n_state = S_JW;
            end
            S_JW:  n_state = S_UP;
            S_RPT: n_state = S_RPT_W;
            S_RPT_W: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out.black_runs  = runs32[9:0];
                    n_out.black_cells = len32[10:0];
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_v;
        mem_raddr   = r_v;
        mem_wdata   = solid(r_rdata.tagc, v_size >> 1);
        o_req_ready = (r_state == S_IDLE);
        o_rsp_valid = r_out_valid;
        o_rsp       = r_out;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_VISIT: begin
                if (r_a <= v_lo && v_hi <= r_b) begin
                    mem_we    = 1'b1;
                    mem_wdata = solid(r_col, v_size);
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_VCHK: begin
                if (r_rdata.tag) begin
                    mem_we    = 1'b1;
                    mem_waddr = left_c;
                end
            end
            S_PUSH_R: begin
                mem_we    = 1'b1;
                mem_waddr = right_c;
            end
            S_JRL: begin
                mem_re    = 1'b1;
                mem_raddr = left_c;
            end
            S_JRR: begin
                mem_re    = 1'b1;
                mem_raddr = right_c;
            end
            S_JW: begin
                mem_we    = 1'b1;
                mem_wdata = join_nodes(r_left, r_rdata);
            end
            S_RPT: begin
                mem_re    = 1'b1;
                mem_raddr = CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_v    <= n_v;
        r_d    <= n_d;
        r_a    <= n_a;
        r_b    <= n_b;
        r_col  <= n_col;
        r_left <= n_left;
        r_out  <= n_out;
    end

endmodule
`default_nettype wire

>>> sim/tb_interval_paint_run_counter.sv
// Testbench for the interval paint run counter: directed and random paint requests checked against a cell-line model.
`default_nettype none
module tb_interval_paint_run_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import ipr_pkg::*;

    localparam int unsigned CELLS = 1 << LEVELS_DEF;
    localparam int unsigned N_RAND = 456;
    localparam longint unsigned CYCLE_LIMIT = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_paint_req i_req = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_paint_rsp o_rsp;

    interval_paint_run_counter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always #4 i_clk = ~i_clk;

    t_paint_req pending_reqs[$];
    t_paint_rsp expected_counts[$];
    bit line_cells[CELLS];
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned holdoff_cycles = 0;
    int unsigned fail_count = 0;
    longint unsigned cycle_count = 0;

    function automatic t_paint_rsp paint_and_count(t_paint_req r);
        t_paint_rsp c;
        int unsigned stop;
        int unsigned runs;
        int unsigned cells;
        runs = 0;
        cells = 0;
        if (r.range_length != 0) begin
            stop = 32'(r.range_start) + 32'(r.range_length);
            if (stop > CELLS) stop = CELLS;
            for (int unsigned k = r.range_start; k < stop; k++) line_cells[k] = r.paint_black;
        end
        for (int unsigned k = 0; k < CELLS; k++) begin
            if (line_cells[k]) begin
                cells++;
                if (k == 0 || !line_cells[k-1]) runs++;
            end
        end
        c.black_runs = runs[9:0];
        c.black_cells = cells[10:0];
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    task automatic queue_req(input t_paint_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    function automatic t_paint_req rand_req();
        t_paint_req r;
        r.paint_black = 1'($urandom_range(0, 1));
        r.range_start = 10'($urandom);
        case ($urandom_range(0, 9))
            0: r.range_length = '0;
            1: r.range_length = 11'($urandom_range(0, 2047));
            2: r.range_length = 11'($urandom_range(512, 1024));
            default: r.range_length = 11'($urandom_range(1, 40));
        endcase
        return r;
    endfunction

    function automatic t_paint_req mk(input bit b, input int unsigned s, input int unsigned l);
        t_paint_req r;
        r.paint_black = b;
        r.range_start = 10'(s);
        r.range_length = 11'(l);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_req_valid || o_req_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    i_req_valid <= 1'b1;
                    i_req <= pending_reqs.pop_front();
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && o_req_ready)
                expected_counts.insert(expected_counts.size(), paint_and_count(i_req));
            if (o_rsp_valid && i_rsp_ready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch("unexpected response", 0, 0);
                end else begin
                    if (o_rsp.black_runs != expected_counts[0].black_runs)
                        report_mismatch("black_runs", 32'(o_rsp.black_runs),
                                        32'(expected_counts[0].black_runs));
                    if (o_rsp.black_cells != expected_counts[0].black_cells)
                        report_mismatch("black_cells", 32'(o_rsp.black_cells),
                                        32'(expected_counts[0].black_cells));
                    void'(expected_counts.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (holdoff_cycles > 0) begin
                holdoff_cycles <= holdoff_cycles - 1;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || i_req_valid || expected_counts.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned n, input int unsigned idle,
                             input int unsigned stall);
        src_idle_pct = idle;
        sink_stall_pct = stall;
        for (int unsigned k = 0; k < n; k++) queue_req(rand_req());
        drain();
    endtask

    initial begin
        for (int unsigned k = 0; k < CELLS; k++) line_cells[k] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        queue_req(mk(1, 5, 0));
        queue_req(mk(1, 0, 1));
        queue_req(mk(1, 1023, 1));
        queue_req(mk(1, 1023, 2047));
        queue_req(mk(1, 10, 5));
        queue_req(mk(1, 16, 4));
        queue_req(mk(1, 15, 1));
        queue_req(mk(0, 12, 1));
        queue_req(mk(1, 0, 1024));
        queue_req(mk(0, 0, 1024));
        queue_req(mk(1, 512, 1024));
        queue_req(mk(0, 700, 1));
        queue_req(mk(1, 1000, 1023));
        queue_req(mk(0, 341, 682));
        queue_req(mk(1, 682, 0));
        queue_req(mk(0, 0, 2047));
        for (int unsigned k = 0; k < 256; k += 2) queue_req(mk(1, k, 1));
        queue_req(mk(0, 0, 1024));
        drain();
        run_phase(N_RAND / 4, 0, 0);
        run_phase(N_RAND / 4, 76, 0);
        run_phase(N_RAND / 4, 0, 76);
        run_phase(N_RAND / 8, 15, 15);
        holdoff_cycles = 3000;
        run_phase(N_RAND / 8, 0, 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && expected_counts.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> interval_paint_run_counter.f
design/ipr_pkg.sv
design/interval_paint_run_counter.sv
sim/tb_interval_paint_run_counter.sv
